// ===== src/velocity_frame_receiver_defines.svh =====
// ---------------------------------------------------------------------------
// velocity_frame_receiver_defines
// Assertion macros used by the velocity frame receiver parser.
// ---------------------------------------------------------------------------
`ifndef VELOCITY_FRAME_RECEIVER_DEFINES_SVH
`define VELOCITY_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define VFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/vfr_pkg.sv =====
// ---------------------------------------------------------------------------
// vfr_pkg
// Shared types, constants and helpers of the velocity frame receiver.
// ---------------------------------------------------------------------------
package vfr_pkg;

   localparam int unsigned PAYLOAD_BYTES = 8;
   localparam int unsigned VEL_COUNT     = 4;
   localparam int unsigned VEL_IDX_W     = $clog2(VEL_COUNT);
   localparam int unsigned COUNT_W       = $clog2(PAYLOAD_BYTES + 1);

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_SELECT = 2'd1;

   // register reset values
   localparam logic [7:0] HEADER_RESET = 8'hAA;
   localparam logic [2:0] MOTOR_RESET  = 3'd2;

   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(PAYLOAD_BYTES);

   typedef struct packed {
      logic               frame_status;
      logic signed [15:0] velocity;
   } vfr_result_type;

   // one-based motor select to slot index, clamped to the valid range
   function automatic logic [VEL_IDX_W-1:0] select_slot(input logic [2:0] motor_select);
      logic [VEL_IDX_W-1:0] slot;
      if (motor_select == 3'd0) begin
         slot = '0;
      end else if (motor_select >= 3'(VEL_COUNT)) begin
         slot = VEL_IDX_W'(VEL_COUNT - 1);
      end else begin
         slot = VEL_IDX_W'(motor_select - 3'd1);
      end
      return slot;
   endfunction

endpackage

// ===== src/velocity_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// velocity_frame_receiver
// Pulls header-started velocity frames with an additive checksum out of a
// byte stream and reports pass or fail with one selected velocity.
// ---------------------------------------------------------------------------
// Accepts one byte per clock cycle. A byte is held in an input register and
// processed against the frame state once the output register can take a
// result. Its result, which only a checksum byte has, is loaded into the
// output register at the end of that cycle. Throughput drops below one byte
// per cycle only while a result waits in the output register with rsp_ready
// low. Bytes other than the header are dropped while hunting. A frame is the
// header, then eight payload bytes that form four little-endian signed
// velocities, then a checksum byte equal to the 8-bit payload sum.
// Registers: index 0 header byte (reset 0xAA), index 1 one-based motor
// select (reset 2, 0 reads as 1, 5 to 7 read as 4). Write them only while
// the block holds no unprocessed byte or pending result.
module velocity_frame_receiver (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_frame_status,
   output logic signed [15:0]             rsp_velocity,
   input  logic                           csr_we,
   input  logic [vfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vfr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import vfr_pkg::*;

   logic [7:0]     header_ff;
   logic [2:0]     motor_ff;
   logic           in_vld_ff, in_vld_in;
   logic [7:0]     in_byte_ff;
   logic           slot_free;
   logic           advance;
   logic           res_vld;
   vfr_result_type res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         motor_ff  <= MOTOR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_BYTE:  header_ff <= csr_wdata[7:0];
            CSR_MOTOR_SELECT: motor_ff  <= csr_wdata[2:0];
            default:          ;
         endcase
      end
   end

   // input register, drains whenever the result slot can take a result
   assign advance   = in_vld_ff && slot_free;
   assign req_ready = !in_vld_ff || slot_free;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // frame parsing
   vfr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_vld     (advance),
      .rx_byte      (in_byte_ff),
      .header_byte  (header_ff),
      .motor_select (motor_ff),
      .res_vld      (res_vld),
      .res          (res)
   );

   // result register
   vfr_rsp_reg u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (res_vld),
      .res              (res),
      .slot_free        (slot_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_status (rsp_frame_status),
      .rsp_velocity     (rsp_velocity)
   );

endmodule

// ===== src/vfr_parser.sv =====
// ---------------------------------------------------------------------------
// vfr_parser
// Frame state, payload store and checksum check, one byte per cycle while byte_vld is high.
// ---------------------------------------------------------------------------
`include "velocity_frame_receiver_defines.svh"

module vfr_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_vld,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             header_byte,
   input  logic [2:0]             motor_select,
   output logic                   res_vld,
   output vfr_pkg::vfr_result_type res
);
   import vfr_pkg::*;

   logic                 in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [7:0]           sum_ff, sum_in;
   logic [15:0]          vel_ff [VEL_COUNT];
   logic [VEL_IDX_W-1:0] wr_slot;
   logic                 payload_byte;
   logic                 check_byte;

   // byte classification
   assign payload_byte = byte_vld && in_frame_ff && (count_ff < LAST_COUNT);
   assign check_byte   = byte_vld && in_frame_ff && (count_ff == LAST_COUNT);
   assign wr_slot      = count_ff[VEL_IDX_W:1];

   // frame state next values
   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      if (byte_vld) begin
         if (!in_frame_ff) begin
            count_in = '0;
            if (rx_byte == header_byte) begin
               in_frame_in = 1'b1;
               sum_in      = '0;
            end
         end else if (payload_byte) begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + rx_byte;
         end else begin
            in_frame_in = 1'b0;
            count_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         sum_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
      end
   end

   // payload store, low byte first
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VEL_COUNT; i++) begin
            vel_ff[i] <= '0;
         end
      end else if (payload_byte) begin
         if (count_ff[0] == 1'b0) begin
            vel_ff[wr_slot][7:0] <= rx_byte;
         end else begin
            vel_ff[wr_slot][15:8] <= rx_byte;
         end
      end
   end

   // checksum compare and result
   always_comb begin
      res_vld = check_byte;
      if (sum_ff == rx_byte) begin
         res.frame_status = 1'b0;
         res.velocity     = vel_ff[select_slot(motor_select)];
      end else begin
         res.frame_status = 1'b1;
         res.velocity     = '0;
      end
   end

   `VFR_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= LAST_COUNT,
      "payload count out of range")
   `VFR_ASSERT_SAME(a_hunt_count, clock, reset, !in_frame_ff, count_ff == '0,
      "payload count not cleared while hunting")
   `VFR_ASSERT_NEXT(a_back_to_hunt, clock, reset, res_vld, !in_frame_ff,
      "frame not closed after checksum byte")
   `VFR_ASSERT_SAME(a_fail_zero, clock, reset, res_vld && res.frame_status,
      res.velocity == '0, "failed frame reports nonzero velocity")

endmodule

// ===== src/vfr_rsp_reg.sv =====
// ---------------------------------------------------------------------------
// vfr_rsp_reg
// Result register on the response side; holds a result until transfer.
// ---------------------------------------------------------------------------
module vfr_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  vfr_pkg::vfr_result_type res,
   output logic                   slot_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_frame_status,
   output logic signed [15:0]     rsp_velocity
);
   import vfr_pkg::*;

   logic           valid_ff, valid_in;
   vfr_result_type res_ff;

   // slot can take a new result when empty or emptied this cycle
   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_status = res_ff.frame_status;
   assign rsp_velocity     = res_ff.velocity;

endmodule

// ===== tb/vfr_result_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vfr_result_checker
// Watches the byte, result and register ports of the velocity frame
// receiver, keeps its own model of frame hunting, payload storage and the
// additive checksum, and compares every result transfer with the oldest
// predicted frame verdict.
// ---------------------------------------------------------------------------
module vfr_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [7:0]                     req_rx_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_frame_status,
   input  logic signed [15:0]             rsp_velocity,
   input  logic                           csr_we,
   input  logic [vfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vfr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    mismatch_count,
   output int unsigned                    pending_count
);

   // predicted frame verdicts, oldest first
   vfr_pkg::vfr_result_type verdict_q [$];
   int unsigned             fail_tally = 0;
   int unsigned             verdicts_waiting = 0;

   // mirrored registers
   logic [7:0]  header_value;
   logic [2:0]  motor_sel;

   // mirrored frame state
   bit          in_frame;
   logic [3:0]  byte_count;
   logic [7:0]  running_sum;
   logic [15:0] vel_slot [4];

   assign mismatch_count = fail_tally;
   assign pending_count  = verdicts_waiting;

   task automatic log_mismatch(input string what, input int want_v, input int got_v);
      if (fail_tally < 10) begin
         $display("%0t: %s: expected %0d, got %0d", $time, what, want_v, got_v);
      end
      fail_tally++;
   endtask

   // one byte through the deframer, returns 1 when a checksum byte closes a frame
   function automatic bit advance_frame(input logic [7:0] rx, output vfr_pkg::vfr_result_type res);
      logic [1:0] slot;
      res = '0;
      // header hunt drops everything but the header value
      if (!in_frame) begin
         byte_count = 4'd0;
         if (rx == header_value) begin
            in_frame    = 1'b1;
            running_sum = 8'd0;
         end
         return 1'b0;
      end
      // payload, low byte first
      if (byte_count < 4'(vfr_pkg::PAYLOAD_BYTES)) begin
         slot = byte_count[2:1];
         if (!byte_count[0]) begin
            vel_slot[slot][7:0] = rx;
         end else begin
            vel_slot[slot][15:8] = rx;
         end
         byte_count  = byte_count + 4'd1;
         running_sum = running_sum + rx;
         return 1'b0;
      end
      // checksum byte, out-of-range selects clamp to the nearest slot
      if (running_sum == rx) begin
         case (motor_sel)
            3'd0, 3'd1: slot = 2'd0;
            3'd2:       slot = 2'd1;
            3'd3:       slot = 2'd2;
            default:    slot = 2'd3;
         endcase
         res.frame_status = 1'b0;
         res.velocity     = vel_slot[slot];
      end else begin
         res.frame_status = 1'b1;
         res.velocity     = 16'sd0;
      end
      in_frame   = 1'b0;
      byte_count = 4'd0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : monitor
      vfr_pkg::vfr_result_type want;
      vfr_pkg::vfr_result_type predicted;
      if (reset) begin
         header_value     = vfr_pkg::HEADER_RESET;
         motor_sel        = vfr_pkg::MOTOR_RESET;
         in_frame         = 1'b0;
         byte_count       = 4'd0;
         running_sum      = 8'd0;
         for (int i = 0; i < 4; i++) vel_slot[i] = 16'd0;
         verdict_q.delete();
         verdicts_waiting = 0;
      end else begin
         // register writes, unknown indexes are ignored
         if (csr_we) begin
            if (csr_index == vfr_pkg::CSR_HEADER_BYTE) begin
               header_value = csr_wdata[7:0];
            end else if (csr_index == vfr_pkg::CSR_MOTOR_SELECT) begin
               motor_sel = csr_wdata[2:0];
            end
         end
         // result transfer against the oldest verdict
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               log_mismatch("result with no frame pending, status", -1, rsp_frame_status);
            end else begin
               want = verdict_q.pop_front();
               verdicts_waiting--;
               if (rsp_frame_status !== want.frame_status) begin
                  log_mismatch("frame_status", want.frame_status, rsp_frame_status);
               end
               if (rsp_velocity !== want.velocity) begin
                  log_mismatch("velocity", int'($signed(want.velocity)),
                               int'($signed(rsp_velocity)));
               end
            end
         end
         // byte transfer into the model
         if (req_valid && req_ready) begin
            if (advance_frame(req_rx_byte, predicted)) begin
               verdict_q.push_back(predicted);
               verdicts_waiting++;
            end
         end
      end
   end

endmodule

// ===== tb/tb_velocity_frame_receiver.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_velocity_frame_receiver
// Drives byte streams into the velocity frame receiver: directed frames at
// the field extremes, then random well-formed, truncated and noisy frames
// over several header and motor select settings and idling patterns, with a
// long result hold-off to back the block up. A separate checker predicts
// and compares every result.
// ---------------------------------------------------------------------------
module tb_velocity_frame_receiver;

   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned ITEM_TARGET    = 1300;
   localparam int unsigned PHASE_COUNT    = 8;

   // indexes past the register list
   localparam logic [vfr_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [vfr_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [7:0]                     req_rx_byte;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic                           rsp_frame_status;
   logic signed [15:0]             rsp_velocity;
   logic                           csr_we;
   logic [vfr_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [vfr_pkg::CSR_DATA_W-1:0] csr_wdata;

   int unsigned mismatch_count;
   int unsigned pending_count;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_requests  = 0;
   int unsigned holds_served   = 0;
   int unsigned frame_bytes    = 0;
   logic [7:0]  cur_header     = vfr_pkg::HEADER_RESET;

   velocity_frame_receiver dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_status (rsp_frame_status),
      .rsp_velocity     (rsp_velocity),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   vfr_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_status (rsp_frame_status),
      .rsp_velocity     (rsp_velocity),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // result side: random stalls, or a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tb_velocity_frame_receiver: FAIL");
      $finish;
   end

   // one byte transfer, valid stays up for a back-to-back byte
   task automatic send_byte(input logic [7:0] rx, input bit counts);
      bit taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      if (counts) frame_bytes++;
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   // header, eight payload bytes, checksum shifted by chk_offset (0 is correct)
   task automatic send_frame(input logic [7:0] hdr, input logic [63:0] body,
                             input logic [7:0] chk_offset);
      logic [7:0] sum;
      sum = 8'd0;
      send_byte(hdr, 1'b1);
      for (int i = 0; i < 8; i++) begin
         send_byte(body[8*i +: 8], 1'b1);
         sum = sum + body[8*i +: 8];
      end
      send_byte(sum + chk_offset, 1'b1);
   endtask

   // payload with a bias toward extreme bytes
   function automatic logic [63:0] random_body();
      logic [63:0] body;
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(7))
            0:       body[8*i +: 8] = 8'h00;
            1:       body[8*i +: 8] = 8'hFF;
            2:       body[8*i +: 8] = $urandom_range(1) ? 8'h80 : 8'h7F;
            default: body[8*i +: 8] = 8'($urandom_range(255));
         endcase
      end
      return body;
   endfunction

   // wait for every verdict, then let the input register empty
   task automatic wait_drained();
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [vfr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [vfr_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [7:0]  phase_header [PHASE_COUNT];
      logic [2:0]  phase_motor  [PHASE_COUNT];
      int unsigned phase_target;
      logic [7:0]  noise;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'd0;
      csr_we      = 1'b0;
      csr_index   = vfr_pkg::CSR_HEADER_BYTE;
      csr_wdata   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: noise while hunting, extreme velocities, header bytes inside a frame
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_frame(vfr_pkg::HEADER_RESET, 64'hFFFF_8000_7FFF_0000, 8'h00);
      send_frame(vfr_pkg::HEADER_RESET, {8{8'hAA}}, 8'h5A);
      stop_sending();
      wait_drained();

      phase_header[0] = 8'h00;
      phase_header[1] = 8'hFF;
      phase_header[2] = 8'h55;
      phase_header[3] = vfr_pkg::HEADER_RESET;
      phase_header[4] = 8'($urandom_range(255));
      phase_header[5] = 8'($urandom_range(255));
      phase_header[6] = 8'h01;
      phase_header[7] = 8'h80;
      for (int p = 0; p < PHASE_COUNT; p++) phase_motor[p] = 3'(p);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         // settings for this phase, written while idle
         write_reg(vfr_pkg::CSR_HEADER_BYTE, vfr_pkg::CSR_DATA_W'(phase_header[p]));
         cur_header = phase_header[p];
         write_reg(vfr_pkg::CSR_MOTOR_SELECT, vfr_pkg::CSR_DATA_W'(phase_motor[p]));
         if (p == 3) write_reg(CSR_SPARE_A, vfr_pkg::CSR_DATA_W'($urandom_range(255)));
         if (p == 6) write_reg(CSR_SPARE_B, vfr_pkg::CSR_DATA_W'($urandom_range(255)));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         // back the block up while bytes keep coming
         if (p == 0 || p == 4) hold_requests <= hold_requests + 1;

         phase_target = frame_bytes + ITEM_TARGET / PHASE_COUNT;
         while (frame_bytes < phase_target) begin
            case ($urandom_range(9))
               8: begin
                  // truncated frame, the next bytes get absorbed into it
                  send_byte(cur_header, 1'b1);
                  repeat ($urandom_range(7)) send_byte(8'($urandom_range(255)), 1'b1);
               end
               9: begin
                  repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(255)), 1'b1);
               end
               default: begin
                  // well-formed frame after a little noise, checksum sometimes wrong
                  repeat ($urandom_range(2)) begin
                     do noise = 8'($urandom_range(255)); while (noise == cur_header);
                     send_byte(noise, 1'b0);
                  end
                  send_frame(cur_header, random_body(),
                             ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
               end
            endcase
         end
         stop_sending();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (pending_count != 0) begin
         $display("%0d expected results never arrived", pending_count);
      end
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_velocity_frame_receiver: PASS");
      end else begin
         $display("tb_velocity_frame_receiver: FAIL");
      end
      $finish;
   end

endmodule
